### rtl/htfd_pkg.sv
// Package with the types, constants and helper functions of the sensor frame decoder.
`timescale 1ns / 1ps

package htfd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;
    localparam logic [30:0] TEMP_SPAN   = 31'd17500;
    localparam logic [30:0] HUM_SPAN    = 31'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    // Position of the next byte inside a six-byte frame.
    typedef enum logic [2:0] {
        POS_TEMP_MSB = 3'd0,
        POS_TEMP_LSB = 3'd1,
        POS_TEMP_CRC = 3'd2,
        POS_HUM_MSB  = 3'd3,
        POS_HUM_LSB  = 3'd4,
        POS_HUM_CRC  = 3'd5
    } pos_t;

    // A completed frame as it leaves the byte stage.
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] humid_word;
        logic        crc_ok;
        logic [31:0] count;
    } frame_t;

    // A completed frame after scaling to hundredths.
    typedef struct packed {
        logic signed [14:0] temperature;
        logic [13:0]        humidity;
        logic               crc_ok;
        logic [31:0]        count;
    } scaled_t;

    // One byte of CRC-8, MSB first, no final xor.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Floor division by 65535 for values below 2^31. With x = q0*65536 + lo, the
    // remainder against 65535 is lo + q0, which stays below twice the divisor.
    function automatic logic [14:0] div_65535(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] r;
        logic [14:0] q;
        q0 = x[30:16];
        r  = {1'b0, x[15:0]} + {2'b00, q0};
        q  = q0 + {14'd0, (r >= FULL_SCALE)};
        return q;
    endfunction

endpackage

### rtl/htfd_if.sv
// Handshake interfaces for the frame byte channel and the result channel.
`timescale 1ns / 1ps

interface htfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       first_byte;

    modport source (output valid, output rx_byte, output first_byte, input ready);
    modport sink   (input valid, input rx_byte, input first_byte, output ready);
endinterface

interface htfd_result_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               crc_ok;
    logic [31:0]        frame_count;

    modport source (output valid, output temperature_centi, output humidity_centi,
                    output crc_ok, output frame_count, input ready);
    modport sink   (input valid, input temperature_centi, input humidity_centi,
                    input crc_ok, input frame_count, output ready);
endinterface

### rtl/humidity_temperature_frame_decoder_core.sv
// Top level of the sensor frame decoder: byte stage, scaling stage and result register.
// Throughput: one byte transfer per cycle, sustained, while results are taken.
// After the transfer of its sixth byte, a frame is registered in the scaling stage and then in the result register.
// The scaling stage and the result register decouple the byte input from result stalls.
// Reset clears the byte position, CRC, words, held values, frame count and valid flags.
`timescale 1ns / 1ps

module humidity_temperature_frame_decoder_core (
    input  logic clk,
    input  logic rst_n,
    htfd_byte_if.sink     frame_bytes,
    htfd_result_if.source results
);
    import htfd_pkg::*;

    pos_t               pos_reg, pos_next, pos_cur;
    logic [7:0]         crc_reg, crc_next, crc_cur;
    logic [15:0]        temp_word_reg, temp_word_next;
    logic [15:0]        humid_word_reg, humid_word_next;
    logic               temp_good_reg, temp_good_next;
    logic [31:0]        count_reg, count_next;
    logic               frame_done;
    logic               frame_ok;
    logic               in_xfer;

    logic               scale_valid;
    logic               scale_free;
    logic               out_load;
    frame_t             frame;
    scaled_t            scaled;

    logic signed [14:0] held_temp_reg;
    logic [13:0]        held_hum_reg;
    logic               res_valid_reg;
    logic signed [14:0] res_temp_reg;
    logic [13:0]        res_hum_reg;
    logic               res_ok_reg;
    logic [31:0]        res_count_reg;

    assign out_load          = !res_valid_reg || results.ready;
    assign scale_free        = !scale_valid || out_load;
    assign frame_bytes.ready = scale_free;
    assign in_xfer           = frame_bytes.valid && frame_bytes.ready;

    // Byte stage: a first-byte mark restarts the frame before the byte is used.
    always_comb
    begin
        pos_cur         = frame_bytes.first_byte ? POS_TEMP_MSB : pos_reg;
        crc_cur         = frame_bytes.first_byte ? CRC_INIT : crc_reg;
        pos_next        = pos_cur;
        crc_next        = crc_cur;
        temp_word_next  = temp_word_reg;
        humid_word_next = humid_word_reg;
        temp_good_next  = temp_good_reg;
        count_next      = count_reg;
        frame_done      = 1'b0;
        frame_ok        = 1'b0;
        unique case (pos_cur)
            POS_TEMP_MSB:
            begin
                temp_word_next = {frame_bytes.rx_byte, 8'h00};
                crc_next       = crc8_update(crc_cur, frame_bytes.rx_byte);
                pos_next       = POS_TEMP_LSB;
            end
            POS_TEMP_LSB:
            begin
                temp_word_next = temp_word_reg | {8'h00, frame_bytes.rx_byte};
                crc_next       = crc8_update(crc_cur, frame_bytes.rx_byte);
                pos_next       = POS_TEMP_CRC;
            end
            POS_TEMP_CRC:
            begin
                temp_good_next = (crc_cur == frame_bytes.rx_byte);
                crc_next       = CRC_INIT;
                pos_next       = POS_HUM_MSB;
            end
            POS_HUM_MSB:
            begin
                humid_word_next = {frame_bytes.rx_byte, 8'h00};
                crc_next        = crc8_update(crc_cur, frame_bytes.rx_byte);
                pos_next        = POS_HUM_LSB;
            end
            POS_HUM_LSB:
            begin
                humid_word_next = humid_word_reg | {8'h00, frame_bytes.rx_byte};
                crc_next        = crc8_update(crc_cur, frame_bytes.rx_byte);
                pos_next        = POS_HUM_CRC;
            end
            POS_HUM_CRC:
            begin
                frame_done = 1'b1;
                frame_ok   = temp_good_reg && (crc_cur == frame_bytes.rx_byte);
                crc_next   = CRC_INIT;
                count_next = count_reg + 32'd1;
                pos_next   = POS_TEMP_MSB;
            end
            default:
            begin
                pos_next = POS_TEMP_MSB;
                crc_next = CRC_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_TEMP_MSB;
            crc_reg        <= CRC_INIT;
            temp_word_reg  <= 16'd0;
            humid_word_reg <= 16'd0;
            temp_good_reg  <= 1'b0;
            count_reg      <= 32'd0;
        end
        else if (in_xfer)
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            temp_word_reg  <= temp_word_next;
            humid_word_reg <= humid_word_next;
            temp_good_reg  <= temp_good_next;
            count_reg      <= count_next;
        end
    end

    assign frame.temp_word  = temp_word_reg;
    assign frame.humid_word = humid_word_next;
    assign frame.crc_ok     = frame_ok;
    assign frame.count      = count_next;

    htfd_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (in_xfer && frame_done),
        .advance (out_load),
        .frame   (frame),
        .valid   (scale_valid),
        .result  (scaled)
    );

    // Held values change only when a frame with both CRCs good reaches the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            held_temp_reg <= 15'sd0;
            held_hum_reg  <= 14'd0;
        end
        else if (out_load)
        begin
            res_valid_reg <= scale_valid;
            if (scale_valid && scaled.crc_ok)
            begin
                held_temp_reg <= scaled.temperature;
                held_hum_reg  <= scaled.humidity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && scale_valid)
        begin
            res_temp_reg  <= scaled.crc_ok ? scaled.temperature : held_temp_reg;
            res_hum_reg   <= scaled.crc_ok ? scaled.humidity : held_hum_reg;
            res_ok_reg    <= scaled.crc_ok;
            res_count_reg <= scaled.count;
        end
    end

    assign results.valid             = res_valid_reg;
    assign results.temperature_centi = res_temp_reg;
    assign results.humidity_centi    = res_hum_reg;
    assign results.crc_ok            = res_ok_reg;
    assign results.frame_count       = res_count_reg;

    // The CRC is always at its initial value when a new word starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == POS_TEMP_MSB || pos_reg == POS_HUM_MSB) |-> crc_reg == CRC_INIT)
        else $error("CRC not restarted at the start of a word");

    // The sixth byte of a frame always lands in the scaling stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && frame_done) |=> scale_valid)
        else $error("completed frame lost before scaling");

    // Scaled values stay inside the sensor range.
    assert property (@(posedge clk) disable iff (!rst_n)
        scale_valid |-> (scaled.temperature >= -15'sd4500 && scaled.temperature <= 15'sd13000
                         && scaled.humidity <= 14'd10000))
        else $error("scaled value out of range");

    // The held values are what a good frame delivers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_ok_reg) |-> (res_temp_reg == held_temp_reg
                                           && res_hum_reg == held_hum_reg))
        else $error("held values differ from the last good result");

endmodule

### rtl/htfd_scale.sv
// Scaling stage: registers the raw products of a completed frame and converts them.
`timescale 1ns / 1ps

module htfd_scale (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic            advance,
    input  htfd_pkg::frame_t  frame,
    output logic            valid,
    output htfd_pkg::scaled_t result
);
    import htfd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [30:0] temp_prod_reg;
    logic [30:0] hum_prod_reg;
    logic        ok_reg;
    logic [31:0] count_reg;
    logic [14:0] temp_q;
    logic [14:0] hum_q;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            temp_prod_reg <= {15'd0, frame.temp_word} * TEMP_SPAN;
            hum_prod_reg  <= {15'd0, frame.humid_word} * HUM_SPAN;
            ok_reg        <= frame.crc_ok;
            count_reg     <= frame.count;
        end
    end

    assign temp_q = div_65535(temp_prod_reg);
    assign hum_q  = div_65535(hum_prod_reg);

    assign valid              = valid_reg;
    assign result.temperature = $signed(temp_q - TEMP_OFFSET);
    assign result.humidity    = hum_q[13:0];
    assign result.crc_ok      = ok_reg;
    assign result.count       = count_reg;

endmodule
